### rtl/resf_pkg.sv
`timescale 1ns / 1ps

package resf_pkg;

    // Field formats
    localparam int LEN_FRAC_BITS_DEF = 16;
    localparam int KS_FRAC           = 16;
    localparam int TAN_FRAC          = 30;

    // Stream widths
    localparam int TAG_W = 16;
    localparam int IN_W  = 208;
    localparam int OUT_W = 656;

    // Divider datapath
    localparam int LANES  = 10;
    localparam int NUM_W  = 128;
    localparam int DEN_W  = 64;
    localparam int QUO_W  = 64;
    localparam int NCELL  = QUO_W;
    localparam int WIDE_W = NUM_W + 64;

    // Lane allocation
    localparam int LANE_ENERGY = 0;
    localparam int LANE_FORCE  = 1;
    localparam int LANE_JAC    = 4;
    localparam int NPAIR       = 6;

    // Index pairs of the six unique Jacobian entries
    localparam int PAIR_I [NPAIR] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_J [NPAIR] = '{0, 1, 2, 1, 2, 2};

    // Configuration port
    localparam int  ADDR_W    = 3;
    localparam int  APB_W     = 32;
    localparam logic REG_EXACT = 1'b0;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        lane_t [LANES-1:0]       lane;
    } word_t;

    // Clamp a sign-magnitude quotient into the signed 64-bit range
    function automatic logic [63:0] sat64(logic [QUO_W-1:0] q, logic neg, logic ovf);
        logic [63:0] r;
        if (!neg)
        begin
            r = (ovf || q[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : q;
        end
        else
        begin
            r = (ovf || (q > 64'h8000_0000_0000_0000)) ? 64'h8000_0000_0000_0000
                                                       : (~q + 64'd1);
        end
        return r;
    endfunction

endpackage

### rtl/resf_prep.sv
`timescale 1ns / 1ps

module resf_prep #(
    parameter int LEN_FRAC_BITS = resf_pkg::LEN_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [resf_pkg::IN_W-1:0] in_data,
    input  logic                      exact,
    output logic                      out_valid,
    output resf_pkg::word_t           out_word
);

    localparam int NP = resf_pkg::NPAIR;
    // Scaling of each numerator before the division by L or L*l
    localparam int EN_UP  = 32;
    localparam int EN_DN  = 1 + resf_pkg::KS_FRAC + LEN_FRAC_BITS;
    localparam int FO_UP  = 32;
    localparam int FO_DN  = resf_pkg::KS_FRAC + resf_pkg::TAN_FRAC;
    localparam int JA_UP  = 32 + LEN_FRAC_BITS;
    localparam int JA_DN  = resf_pkg::KS_FRAC + 2 * resf_pkg::TAN_FRAC;

    typedef struct packed {
        logic [resf_pkg::TAG_W-1:0] tag;
        logic                       approx;
        logic                       dneg;
        logic [2:0]                 tn;
        logic [2:0][31:0]           tm;
        logic [31:0]                d;
        logic [31:0]                k;
        logic [31:0]                rl;
        logic [31:0]                cl;
        logic [63:0]                ll;
    } side_t;

    typedef struct packed {
        logic [95:0]         kdd;
        logic [2:0][95:0]    kdt;
        logic [NP-1:0][95:0] ktt;
    } prod_t;

    logic [8:1]  v_reg;
    side_t       side_reg [1:7];
    side_t       side_in;
    side_t       side2_next;

    logic [63:0]         kd2_reg;
    logic [63:0]         tt2_reg [NP];
    logic [63:0]         kdd_lo3_reg, kdd_hi3_reg;
    logic [63:0]         kdt_lo3_reg [3];
    logic [63:0]         kdt_hi3_reg [3];
    logic [63:0]         ktt_lo3_reg [NP];
    logic [63:0]         ktt_hi3_reg [NP];
    logic [63:0]         ttl_lo3_reg [NP];
    logic [63:0]         ttl_hi3_reg [NP];
    prod_t               pr4_reg, pr5_reg, pr6_reg, pr7_reg;
    logic [95:0]         ttl4_reg [NP];
    logic [95:0]         s5_reg [NP];
    logic [NP-1:0]       sn5_reg, sn6_reg, sn7_reg;
    logic [63:0]         sk0_6_reg [NP];
    logic [63:0]         sk1_6_reg [NP];
    logic [63:0]         sk2_6_reg [NP];
    logic [127:0]        sk7_reg [NP];
    resf_pkg::word_t     word_reg;
    resf_pkg::word_t     word_next;

    // Unpack the request, take zero lengths as one LSB, split tangent signs
    always_comb
    begin
        logic [31:0] r;
        logic [31:0] rl0;
        logic [31:0] cl0;
        side_in     = '0;
        side_in.tag = in_data[15:0];
        side_in.k   = in_data[47:16];
        rl0         = in_data[79:48];
        cl0         = in_data[111:80];
        side_in.rl  = (rl0 == 32'd0) ? 32'd1 : rl0;
        side_in.cl  = (cl0 == 32'd0) ? 32'd1 : cl0;
        for (int a = 0; a < 3; a++)
        begin
            r             = in_data[112 + 32*a +: 32];
            side_in.tn[a] = r[31];
            side_in.tm[a] = r[31] ? (~r + 32'd1) : r;
        end
        side_in.dneg   = side_in.cl < side_in.rl;
        side_in.d      = side_in.dneg ? (side_in.rl - side_in.cl)
                                      : (side_in.cl - side_in.rl);
        side_in.approx = !exact && side_in.dneg;
    end

    // Attach L*l to the side band at stage two
    always_comb
    begin
        side2_next    = side_reg[1];
        side2_next.ll = side_reg[1].rl * side_reg[1].cl;
    end

    // Hold request validity per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[7:1], in_valid};
        end
    end

    // Multiply stages: first products, partial products, sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= side_in;
            side_reg[2] <= side2_next;
            for (int s = 3; s <= 7; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end

            kd2_reg <= side_reg[1].k * side_reg[1].d;
            for (int p = 0; p < NP; p++)
            begin
                tt2_reg[p] <= side_reg[1].tm[resf_pkg::PAIR_I[p]]
                            * side_reg[1].tm[resf_pkg::PAIR_J[p]];
            end

            kdd_lo3_reg <= kd2_reg[31:0]  * side_reg[2].d;
            kdd_hi3_reg <= kd2_reg[63:32] * side_reg[2].d;
            for (int a = 0; a < 3; a++)
            begin
                kdt_lo3_reg[a] <= kd2_reg[31:0]  * side_reg[2].tm[a];
                kdt_hi3_reg[a] <= kd2_reg[63:32] * side_reg[2].tm[a];
            end
            for (int p = 0; p < NP; p++)
            begin
                ktt_lo3_reg[p] <= tt2_reg[p][31:0]  * side_reg[2].k;
                ktt_hi3_reg[p] <= tt2_reg[p][63:32] * side_reg[2].k;
                ttl_lo3_reg[p] <= tt2_reg[p][31:0]  * side_reg[2].rl;
                ttl_hi3_reg[p] <= tt2_reg[p][63:32] * side_reg[2].rl;
            end

            pr4_reg.kdd <= {32'd0, kdd_lo3_reg} + {kdd_hi3_reg, 32'd0};
            for (int a = 0; a < 3; a++)
            begin
                pr4_reg.kdt[a] <= {32'd0, kdt_lo3_reg[a]} + {kdt_hi3_reg[a], 32'd0};
            end
            for (int p = 0; p < NP; p++)
            begin
                pr4_reg.ktt[p] <= {32'd0, ktt_lo3_reg[p]} + {ktt_hi3_reg[p], 32'd0};
                ttl4_reg[p]    <= {32'd0, ttl_lo3_reg[p]} + {ttl_hi3_reg[p], 32'd0};
            end

            pr5_reg <= pr4_reg;
            pr6_reg <= pr5_reg;
            pr7_reg <= pr6_reg;
            sn6_reg <= sn5_reg;
            sn7_reg <= sn6_reg;

            for (int p = 0; p < NP; p++)
            begin
                sk0_6_reg[p] <= s5_reg[p][31:0]  * side_reg[5].k;
                sk1_6_reg[p] <= s5_reg[p][63:32] * side_reg[5].k;
                sk2_6_reg[p] <= s5_reg[p][95:64] * side_reg[5].k;
                sk7_reg[p]   <= {64'd0, sk0_6_reg[p]} + {32'd0, sk1_6_reg[p], 32'd0}
                              + {sk2_6_reg[p], 64'd0};
            end

            word_reg <= word_next;
        end
    end

    // Fold the length change into the diagonal of the exact block
    always_ff @(posedge clk)
    begin
        logic [95:0] b;
        logic        sa;
        if (en)
        begin
            b = {4'd0, side_reg[4].d, 60'd0};
            for (int p = 0; p < NP; p++)
            begin
                sa = side_reg[4].tn[resf_pkg::PAIR_I[p]] ^ side_reg[4].tn[resf_pkg::PAIR_J[p]];
                if (resf_pkg::PAIR_I[p] != resf_pkg::PAIR_J[p])
                begin
                    s5_reg[p]  <= ttl4_reg[p];
                    sn5_reg[p] <= sa;
                end
                else if (sa == side_reg[4].dneg)
                begin
                    s5_reg[p]  <= ttl4_reg[p] + b;
                    sn5_reg[p] <= sa;
                end
                else if (ttl4_reg[p] >= b)
                begin
                    s5_reg[p]  <= ttl4_reg[p] - b;
                    sn5_reg[p] <= sa;
                end
                else
                begin
                    s5_reg[p]  <= b - ttl4_reg[p];
                    sn5_reg[p] <= side_reg[4].dneg;
                end
            end
        end
    end

    // Scale numerators, pick denominators and signs, flag quotients past 64 bits
    always_comb
    begin
        logic [resf_pkg::WIDE_W-1:0] w;
        side_t                       sd;
        sd            = side_reg[7];
        word_next     = '0;
        word_next.tag = sd.tag;

        w = resf_pkg::WIDE_W'(pr7_reg.kdd) << EN_UP;
        w = w >> EN_DN;
        word_next.lane[resf_pkg::LANE_ENERGY].rem = w[resf_pkg::NUM_W-1:0];
        word_next.lane[resf_pkg::LANE_ENERGY].den = {32'd0, sd.rl};
        word_next.lane[resf_pkg::LANE_ENERGY].neg = 1'b0;

        for (int a = 0; a < 3; a++)
        begin
            w = resf_pkg::WIDE_W'(pr7_reg.kdt[a]) << FO_UP;
            w = w >> FO_DN;
            word_next.lane[resf_pkg::LANE_FORCE + a].rem = w[resf_pkg::NUM_W-1:0];
            word_next.lane[resf_pkg::LANE_FORCE + a].den = {32'd0, sd.rl};
            word_next.lane[resf_pkg::LANE_FORCE + a].neg = sd.dneg ^ sd.tn[a];
        end

        for (int p = 0; p < NP; p++)
        begin
            if (sd.approx)
            begin
                w = resf_pkg::WIDE_W'(pr7_reg.ktt[p]) << JA_UP;
                word_next.lane[resf_pkg::LANE_JAC + p].den = {32'd0, sd.rl};
                word_next.lane[resf_pkg::LANE_JAC + p].neg =
                    sd.tn[resf_pkg::PAIR_I[p]] ^ sd.tn[resf_pkg::PAIR_J[p]];
            end
            else
            begin
                w = resf_pkg::WIDE_W'(sk7_reg[p]) << JA_UP;
                word_next.lane[resf_pkg::LANE_JAC + p].den = sd.ll;
                word_next.lane[resf_pkg::LANE_JAC + p].neg = sn7_reg[p];
            end
            w = w >> JA_DN;
            word_next.lane[resf_pkg::LANE_JAC + p].rem = w[resf_pkg::NUM_W-1:0];
        end

        for (int l = 0; l < resf_pkg::LANES; l++)
        begin
            word_next.lane[l].quo = '0;
            word_next.lane[l].ovf =
                word_next.lane[l].rem >= {word_next.lane[l].den, 64'd0};
        end
    end

    assign out_valid = v_reg[8];
    assign out_word  = word_reg;

endmodule

### rtl/resf_cell.sv
`timescale 1ns / 1ps

module resf_cell #(
    parameter int BIT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  resf_pkg::word_t in_word,
    output logic            out_valid,
    output resf_pkg::word_t out_word
);

    logic            valid_reg;
    resf_pkg::word_t word_reg;
    resf_pkg::word_t word_next;

    // One restoring step: settle quotient bit BIT in every lane
    always_comb
    begin
        logic [resf_pkg::NUM_W-1:0] sh;
        word_next = in_word;
        for (int l = 0; l < resf_pkg::LANES; l++)
        begin
            sh = resf_pkg::NUM_W'(in_word.lane[l].den) << BIT;
            if (in_word.lane[l].rem >= sh)
            begin
                word_next.lane[l].rem      = in_word.lane[l].rem - sh;
                word_next.lane[l].quo[BIT] = 1'b1;
            end
        end
    end

    // Advance validity with the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hand the partial result to the next cell
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### rtl/rod_edge_stretch_force_top.sv
// Throughput: one edge per cycle while the output is not stalled; an 8-stage
// multiply front end feeds a row of 64 divider cells, each settling one
// quotient bit for all ten results.
// A stalled output freezes the whole pipeline; input is taken whenever the
// output register is empty or being read.
// Reset: all valid flags clear, exact_jacobian returns to 0.
`timescale 1ns / 1ps

module rod_edge_stretch_force_top #(
    parameter int LEN_FRAC_BITS = resf_pkg::LEN_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [resf_pkg::ADDR_W-1:0] paddr,
    input  logic [resf_pkg::APB_W-1:0]  pwdata,
    output logic [resf_pkg::APB_W-1:0]  prdata,
    output logic                        pready,
    // Edge requests
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // edge_index, stiffness, rest_length, cur_length, tan_x, tan_y, tan_z
    input  logic [resf_pkg::IN_W-1:0]   s_axis_tdata,
    // Results
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tag_out, energy, force_x, force_y, force_z,
    // jac_xx, jac_xy, jac_xz, jac_yy, jac_yz, jac_zz
    output logic [resf_pkg::OUT_W-1:0]  m_axis_tdata
);

    logic                        exact_reg;
    logic                        cfg_wr;
    logic                        adv;
    logic                        out_valid_reg;
    logic [resf_pkg::OUT_W-1:0]  out_data_reg;
    logic [resf_pkg::OUT_W-1:0]  out_data_next;
    logic                        cv [resf_pkg::NCELL+1];
    resf_pkg::word_t             cw [resf_pkg::NCELL+1];

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[resf_pkg::ADDR_W-1] == resf_pkg::REG_EXACT);
    assign prdata = (paddr[resf_pkg::ADDR_W-1] == resf_pkg::REG_EXACT)
                  ? {{(resf_pkg::APB_W-1){1'b0}}, exact_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exact_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            exact_reg <= pwdata[0];
        end
    end

    // Advance the pipeline whenever the output slot frees up
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    resf_prep #(
        .LEN_FRAC_BITS (LEN_FRAC_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .exact     (exact_reg),
        .out_valid (cv[0]),
        .out_word  (cw[0])
    );

    // Row of divider cells, most significant quotient bit first
    for (genvar i = 0; i < resf_pkg::NCELL; i++)
    begin : g_cell
        resf_cell #(
            .BIT (resf_pkg::NCELL - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (cv[i]),
            .in_word   (cw[i]),
            .out_valid (cv[i+1]),
            .out_word  (cw[i+1])
        );
    end

    // Clamp each quotient and pack the result
    always_comb
    begin
        out_data_next = '0;
        out_data_next[resf_pkg::TAG_W-1:0] = cw[resf_pkg::NCELL].tag;
        for (int l = 0; l < resf_pkg::LANES; l++)
        begin
            out_data_next[resf_pkg::TAG_W + 64*l +: 64] =
                resf_pkg::sat64(cw[resf_pkg::NCELL].lane[l].quo,
                                cw[resf_pkg::NCELL].lane[l].neg,
                                cw[resf_pkg::NCELL].lane[l].ovf);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= cv[resf_pkg::NCELL];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Energy is a magnitude and never comes out negative
    a_energy_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[resf_pkg::TAG_W + 63])
        else $error("negative energy");

    // A result only appears once the last cell held it
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cv[resf_pkg::NCELL]))
        else $error("result without source");

    // A stalled output freezes the cell row and the front end
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(cv[resf_pkg::NCELL]) && $stable(cv[0])))
        else $error("pipeline moved during stall");

    // The mode register changes only through a write
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(exact_reg) |-> $past(cfg_wr))
        else $error("exact_jacobian changed without write");

endmodule
